### src/lgfa_pkg.sv
// Shared types, codes and constants for the glide-slope / flare altitude unit.
// Used by lgfa_front, lgfa_exp, lgfa_back and the top level.
package lgfa_pkg;

  typedef enum logic [2:0] {
    MODE_SLOPE_REL   = 3'd0,
    MODE_SLOPE_GUARD = 3'd1,
    MODE_FLARE       = 3'd2,
    MODE_SLOPE_ABS   = 3'd3,
    MODE_DISTANCE    = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    CFG_SLOPE_TANGENT    = 3'd0,
    CFG_SLOPE_COTANGENT  = 3'd1,
    CFG_SLOPE_OFFSET     = 3'd2,
    CFG_FLARE_TOP_HEIGHT = 3'd3,
    CFG_VIRTUAL_HEIGHT   = 3'd4,
    CFG_FLARE_LENGTH     = 3'd5,
    CFG_FLARE_RATE       = 3'd6
  } cfg_reg_t;

  localparam int unsigned WIDE_W    = 49;  // widest pre-clamp result
  localparam int unsigned T_W       = 56;  // flare exponent argument, Q.32
  localparam int unsigned REM_W     = 38;  // holds t below the range limit
  localparam int unsigned E_W       = 33;  // exponential, Q.32, up to 1.0
  localparam int unsigned DIV_STEPS = 6;   // quotient bits of t / ln2
  localparam int unsigned EXP_MAX_SHIFT = 40;

  localparam logic [15:0] ROUND_Q16 = 16'h8000;
  localparam logic signed [63:0] ROUND_Q32 = 64'sh0000_0000_8000_0000;

  typedef struct packed {
    logic [18:0]        slope_tangent;
    logic [30:0]        slope_cotangent;
    logic signed [31:0] slope_offset;
    logic signed [31:0] flare_top_height;
    logic signed [31:0] virtual_height;
    logic signed [31:0] flare_length;
    logic [31:0]        flare_rate;
  } cfg_t;

  typedef struct packed {
    logic                     flare_sel;
    logic                     front;
    logic signed [WIDE_W-1:0] wide;
  } side_t;

  typedef struct packed {
    side_t            side;
    logic             big;
    logic [REM_W-1:0] rem;
  } exp_in_t;

  typedef struct packed {
    side_t          side;
    logic [E_W-1:0] e;
  } exp_out_t;

  // -ln(1 - 2^-k) in Q.32, series summed in Q.62; long division done bitwise
  function automatic logic [31:0] neg_ln_step(input int unsigned k);
    logic [63:0] sum;
    logic [63:0] num;
    logic [63:0] quo;
    logic [63:0] rem;
    logic [63:0] rnd;
    sum = '0;
    for (int unsigned j = 1; k * j <= 62; j++) begin
      num = 64'd1 << (62 - k * j);
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
        rem = {rem[62:0], num[b]};
        if (rem >= 64'(j)) begin
          rem    = rem - 64'(j);
          quo[b] = 1'b1;
        end
      end
      sum = sum + quo;
    end
    rnd = sum + (64'd1 << 29);
    return rnd[61:30];
  endfunction

  localparam logic [31:0]    LN2_Q32   = neg_ln_step(1);
  localparam logic [T_W-1:0] EXP_LIMIT = T_W'(LN2_Q32) * T_W'(EXP_MAX_SHIFT);
  localparam logic [E_W-1:0] E_ONE     = E_W'(1) << 32;

endpackage

### src/lgfa_front.sv
// Front end: bearing test, operand differences, the three products and the
// rounded linear results. Three register stages. Depends on lgfa_pkg.
module lgfa_front
  import lgfa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         mode,
  input  logic signed [31:0] distance,
  input  logic [15:0]        track_bearing,
  input  logic [15:0]        aircraft_bearing,
  input  logic signed [31:0] waypoint_altitude,
  input  logic signed [31:0] query_altitude,
  output logic               out_valid,
  input  logic               out_ready,
  output exp_in_t            out_item
);

  logic v1, v2, v3;
  logic r1, r2, r3;

  // stage 1
  mode_t              s1_mode;
  logic               s1_front;
  logic signed [32:0] s1_diff_s;
  logic signed [32:0] s1_diff_q;
  logic [31:0]        s1_x;
  logic signed [31:0] s1_wpalt;

  // stage 2
  mode_t              s2_mode;
  logic               s2_front;
  logic signed [31:0] s2_wpalt;
  logic signed [51:0] s2_prod_s;
  logic signed [63:0] s2_prod_q;
  logic [T_W-1:0]     s2_t;

  logic [15:0]        bear_diff;
  logic               front_now;
  logic signed [32:0] flare_gap;
  logic [63:0]        t_full;
  logic signed [47:0] slope_add;
  logic signed [52:0] slope_sum;
  logic signed [64:0] dist_sum;
  logic signed [WIDE_W-1:0] lin_wide;
  logic               big_now;

  assign r3 = !v3 || out_ready;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign in_ready  = r1;
  assign out_valid = v3;

  // |d| < 90 degrees: top two bits equal, excluding exactly -90
  assign bear_diff = aircraft_bearing - track_bearing;
  assign front_now = (bear_diff[15:14] == 2'b00) ||
                     (bear_diff[15:14] == 2'b11 && bear_diff[13:0] != '0);
  assign flare_gap = 33'(cfg.flare_length) - 33'(distance);

  assign t_full = 64'(s1_x) * 64'(cfg.flare_rate);

  // fold the addend and the rounding half into one add before the shift
  assign slope_add = (s2_mode == MODE_SLOPE_ABS) ? $signed({s2_wpalt, ROUND_Q16})
                                                 : $signed({32'd0, ROUND_Q16});
  assign slope_sum = 53'(s2_prod_s) + 53'(slope_add);
  assign dist_sum  = 65'(s2_prod_q) + 65'($signed({cfg.slope_offset, ROUND_Q16}));
  assign big_now   = s2_t >= EXP_LIMIT;

  always_comb begin
    lin_wide = '0;
    unique case (s2_mode) inside
      MODE_SLOPE_REL, MODE_SLOPE_ABS: lin_wide = WIDE_W'($signed(slope_sum[52:16]));
      MODE_SLOPE_GUARD: begin
        if (s2_front) lin_wide = WIDE_W'($signed(slope_sum[52:16]));
      end
      MODE_DISTANCE: lin_wide = $signed(dist_sum[64:16]);
      default: lin_wide = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && in_valid) begin
      s1_mode   <= mode_t'(mode);
      s1_front  <= front_now;
      s1_diff_s <= 33'(distance) - 33'(cfg.slope_offset);
      s1_diff_q <= 33'(query_altitude) - 33'(waypoint_altitude);
      s1_x      <= flare_gap[32] ? '0 : flare_gap[31:0];
      s1_wpalt  <= waypoint_altitude;
    end
    if (r2 && v1) begin
      s2_mode   <= s1_mode;
      s2_front  <= s1_front;
      s2_wpalt  <= s1_wpalt;
      s2_prod_s <= 52'(s1_diff_s) * 52'($signed({1'b0, cfg.slope_tangent}));
      s2_prod_q <= 64'(s1_diff_q) * 64'($signed({1'b0, cfg.slope_cotangent}));
      s2_t      <= t_full[63:8];
    end
    if (r3 && v2) begin
      out_item.side.flare_sel <= (s2_mode == MODE_FLARE) && s2_front;
      out_item.side.front     <= s2_front;
      out_item.side.wide      <= lin_wide;
      out_item.big            <= big_now;
      out_item.rem            <= big_now ? '0 : s2_t[REM_W-1:0];
    end
  end

endmodule

### src/lgfa_exp.sv
// Flare exponential: restoring division of t by ln2, shift-add iterations,
// then the power-of-two shift. One register stage per step. Depends on lgfa_pkg.
module lgfa_exp
  import lgfa_pkg::*;
#(
  parameter int unsigned EXP_ITERATIONS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  exp_in_t  in_item,
  output logic     out_valid,
  input  logic     out_ready,
  output exp_out_t out_item
);

  localparam int unsigned NST = DIV_STEPS + EXP_ITERATIONS + 1;

  typedef struct packed {
    side_t                side;
    logic                 big;
    logic [DIV_STEPS-1:0] n;
    logic [REM_W-1:0]     rem;
    logic [E_W-1:0]       e;
  } stage_t;

  stage_t         st  [NST];
  stage_t         nxt [NST];
  stage_t         init;
  logic [NST-1:0] vld;
  logic [NST-1:0] src_v;
  logic [NST-1:0] rdy;

  always_comb begin
    init.side = in_item.side;
    init.big  = in_item.big;
    init.n    = '0;
    init.rem  = in_item.rem;
    init.e    = E_ONE;
  end

  assign src_v = {vld[NST-2:0], in_valid};

  // a stage may load when it or any stage after it holds a bubble, or when out_ready is high
  always_comb begin
    for (int i = 0; i < NST; i++) begin
      rdy[i] = out_ready || !(&(vld | ((NST'(1) << i) - NST'(1))));
    end
  end

  assign in_ready      = rdy[0];
  assign out_valid     = vld[NST-1];
  assign out_item.side = st[NST-1].side;
  assign out_item.e    = st[NST-1].e;

  for (genvar i = 0; i < NST; i++) begin : g_st
    stage_t src;
    stage_t nx;

    if (i == 0) begin : g_first
      assign src = init;
    end else begin : g_rest
      assign src = st[i-1];
    end

    if (i < DIV_STEPS) begin : g_div
      localparam logic [REM_W-1:0] DIVISOR = REM_W'(LN2_Q32) << (DIV_STEPS - 1 - i);
      always_comb begin
        nx = src;
        if (src.rem >= DIVISOR) begin
          nx.rem                   = src.rem - DIVISOR;
          nx.n[DIV_STEPS - 1 - i] = 1'b1;
        end
      end
    end else if (i < DIV_STEPS + EXP_ITERATIONS) begin : g_iter
      localparam int unsigned K   = i - DIV_STEPS + 1;
      localparam logic [31:0] C_K = neg_ln_step(K);
      // remainder is below ln2 here, so the low word holds it whole
      always_comb begin
        nx = src;
        if (src.rem[31:0] >= C_K) begin
          nx.rem = src.rem - REM_W'(C_K);
          nx.e   = src.e - (src.e >> K);
        end
      end
    end else begin : g_shift
      always_comb begin
        nx   = src;
        nx.e = src.big ? '0 : (src.e >> src.n);
      end
    end

    assign nxt[i] = nx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (rdy[i]) vld[i] <= src_v[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NST; i++) begin
      if (rdy[i] && src_v[i]) st[i] <= nxt[i];
    end
  end

endmodule

### src/lgfa_back.sv
// Back end: flare height product, rounding, asymptote subtract, result select
// and saturation into the output register. Depends on lgfa_pkg.
module lgfa_back
  import lgfa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  exp_out_t           in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] value,
  output logic               in_front,
  output logic               saturated
);

  logic v1, v2, v3;
  logic r1, r2, r3;

  side_t              b1_side;
  logic signed [63:0] b1_prod;
  side_t              b2_side;
  logic signed [31:0] b2_w;

  logic signed [63:0]       rsum;
  logic signed [32:0]       flare_val;
  logic signed [WIDE_W-1:0] pick;
  logic                     clip;

  assign r3 = !v3 || out_ready;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign in_ready  = r1;
  assign out_valid = v3;

  assign rsum      = b1_prod + ROUND_Q32;
  assign flare_val = 33'(b2_w) - 33'(cfg.virtual_height);
  assign pick      = b2_side.flare_sel ? WIDE_W'(flare_val) : b2_side.wide;
  // in range only when all bits above bit 31 copy the sign
  assign clip      = !((&pick[WIDE_W-1:31]) || !(|pick[WIDE_W-1:31]));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && in_valid) begin
      b1_side <= in_item.side;
      b1_prod <= 64'(cfg.flare_top_height) * 64'($signed({1'b0, in_item.e}));
    end
    if (r2 && v1) begin
      b2_side <= b1_side;
      b2_w    <= rsum[63:32];
    end
    if (r3 && v2) begin
      in_front  <= b2_side.front;
      saturated <= clip;
      if (clip) begin
        value <= pick[WIDE_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
        value <= pick[31:0];
      end
    end
  end

endmodule

### src/landing_glide_flare_altitude.sv
// Pipeline depth grows with EXP_ITERATIONS, set by the six quotient steps and one
// stage per exponential iteration. Throughput: one item per cycle when the output is
// not held; stages with a bubble keep loading while the output register waits.
// Reset clears all valid bits and the configuration registers to zero.
module landing_glide_flare_altitude
  import lgfa_pkg::*;
#(
  parameter int unsigned EXP_ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         mode,
  input  logic signed [31:0] distance,
  input  logic [15:0]        track_bearing,
  input  logic [15:0]        aircraft_bearing,
  input  logic signed [31:0] waypoint_altitude,
  input  logic signed [31:0] query_altitude,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] value,
  output logic               in_front,
  output logic               saturated
);

  cfg_t     cfg;
  logic     fe_valid, fe_ready;
  exp_in_t  fe_item;
  logic     ex_valid, ex_ready;
  exp_out_t ex_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SLOPE_TANGENT:    cfg.slope_tangent    <= cfg_data[18:0];
        CFG_SLOPE_COTANGENT:  cfg.slope_cotangent  <= cfg_data[30:0];
        CFG_SLOPE_OFFSET:     cfg.slope_offset     <= cfg_data;
        CFG_FLARE_TOP_HEIGHT: cfg.flare_top_height <= cfg_data;
        CFG_VIRTUAL_HEIGHT:   cfg.virtual_height   <= cfg_data;
        CFG_FLARE_LENGTH:     cfg.flare_length     <= cfg_data;
        CFG_FLARE_RATE:       cfg.flare_rate       <= cfg_data;
        default: ;
      endcase
    end
  end

  lgfa_front u_front (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .mode              (mode),
    .distance          (distance),
    .track_bearing     (track_bearing),
    .aircraft_bearing  (aircraft_bearing),
    .waypoint_altitude (waypoint_altitude),
    .query_altitude    (query_altitude),
    .out_valid         (fe_valid),
    .out_ready         (fe_ready),
    .out_item          (fe_item)
  );

  lgfa_exp #(
    .EXP_ITERATIONS (EXP_ITERATIONS)
  ) u_exp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fe_valid),
    .in_ready  (fe_ready),
    .in_item   (fe_item),
    .out_valid (ex_valid),
    .out_ready (ex_ready),
    .out_item  (ex_item)
  );

  lgfa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (ex_valid),
    .in_ready  (ex_ready),
    .in_item   (ex_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .in_front  (in_front),
    .saturated (saturated)
  );

  a_sat_at_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> value == 32'sh7fff_ffff || value == 32'sh8000_0000)
    else $error("saturated item not at a range bound");

  a_exp_max_one: assert property (@(posedge clk) disable iff (rst)
    ex_valid |-> ex_item.e <= E_ONE)
    else $error("flare exponential above one");

  a_flare_needs_front: assert property (@(posedge clk) disable iff (rst)
    fe_valid && fe_item.side.flare_sel |-> fe_item.side.front)
    else $error("flare item selected with bearing test failed");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !ex_valid && !fe_valid)
    else $error("pipeline holds an item right after reset");

endmodule

### bench/tb_landing_glide_flare_altitude.sv
// Testbench for landing_glide_flare_altitude: random and directed altitude queries,
// checked one by one against an in-bench predictor of the slope and flare math.
// Depends on lgfa_pkg (mode and register codes) and the RTL top level only.
module tb_landing_glide_flare_altitude;
  timeunit 1ns;
  timeprecision 1ps;
  import lgfa_pkg::*;

  localparam int unsigned EXP_ITERATIONS = 16;
  localparam int LATENCY        = EXP_ITERATIONS + 13;
  localparam int DRAIN_CYCLES   = LATENCY + 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int IDLE_PCT       = 34;
  localparam logic [2:0]  MODE_TOP     = 3'd7;  // highest code the mode port carries
  localparam logic [15:0] QUARTER_TURN = 16'd16384;

  typedef struct {
    logic signed [31:0] value;
    logic               front;
    logic               sat;
  } altitude_result_t;

  class altitude_checker;
    longint          tangent, cotangent, offset, top_height, virt_height, flare_len;
    longint unsigned rate;
    longint unsigned ln_steps[1:32];
    altitude_result_t expected_q[$];
    int n_queries, n_answers, n_errors;

    function new();
      longint unsigned acc;
      // -ln(1 - 2^-k) in Q.32 from its series, summed in Q.62
      for (int k = 1; k <= 32; k++) begin
        acc = 0;
        for (int j = 1; k * j <= 62; j++)
          acc += (64'd1 << (62 - k * j)) / j;
        ln_steps[k] = (acc + (64'd1 << 29)) >> 30;
      end
    endfunction

    function void write_reg(cfg_reg_t idx, logic [31:0] data);
      case (idx)
        CFG_SLOPE_TANGENT:    tangent = data[18:0];
        CFG_SLOPE_COTANGENT:  cotangent = data[30:0];
        CFG_SLOPE_OFFSET:     offset = signed'(data);
        CFG_FLARE_TOP_HEIGHT: top_height = signed'(data);
        CFG_VIRTUAL_HEIGHT:   virt_height = signed'(data);
        CFG_FLARE_LENGTH:     flare_len = signed'(data);
        CFG_FLARE_RATE:       rate = data;
        default: ;
      endcase
    endfunction

    function longint round_q16(longint v);
      return (v + 64'sd32768) >>> 16;
    endfunction

    function longint glide_alt(longint d);
      return round_q16((d - offset) * tangent);
    endfunction

    function longint flare_alt(longint d);
      longint span, e_s, prod;
      longint unsigned x, t, n, r, e;
      span = flare_len - d;
      x = (span > 0) ? span : 0;
      t = (x * rate) >> 8;
      n = t / ln_steps[1];
      r = t - n * ln_steps[1];
      e = 64'd1 << 32;
      if (n >= 40) begin
        e = 0;
      end else begin
        for (int k = 1; k <= EXP_ITERATIONS; k++) begin
          if (r >= ln_steps[k]) begin
            r -= ln_steps[k];
            e -= e >> k;
          end
        end
        e = e >> n;
      end
      e_s = e;
      prod = top_height * e_s;
      return ((prod + 64'sd2147483648) >>> 32) - virt_height;
    endfunction

    function void note_query(logic [2:0] mode_code, logic signed [31:0] dist_in,
                             logic [15:0] track, logic [15:0] craft,
                             logic signed [31:0] wp_alt, logic signed [31:0] q_alt);
      logic [15:0]      wrap;
      shortint          delta;
      logic             front;
      longint           v;
      altitude_result_t res;
      wrap = craft - track;
      delta = signed'(wrap);
      front = (delta < 16384) && (delta > -16384);
      v = 0;
      case (mode_code)
        MODE_SLOPE_REL:   v = glide_alt(dist_in);
        MODE_SLOPE_GUARD: if (front) v = glide_alt(dist_in);
        MODE_FLARE:       if (front) v = flare_alt(dist_in);
        MODE_SLOPE_ABS:   v = glide_alt(dist_in) + wp_alt;
        MODE_DISTANCE:    v = round_q16((longint'(q_alt) - longint'(wp_alt)) * cotangent) + offset;
        default:          v = 0;
      endcase
      res.sat = 1'b0;
      if (v > 64'sd2147483647) begin
        v = 64'sd2147483647;
        res.sat = 1'b1;
      end else if (v < -64'sd2147483648) begin
        v = -64'sd2147483648;
        res.sat = 1'b1;
      end
      res.value = 32'(v);
      res.front = front;
      expected_q.push_back(res);
      n_queries++;
    endfunction

    function void flag(string field, longint want, longint got);
      $error("%s: expected %0d, got %0d", field, want, got);
      n_errors++;
    endfunction

    function void check_answer(logic signed [31:0] value, logic front, logic sat);
      altitude_result_t want;
      n_answers++;
      if (expected_q.size() == 0) begin
        $error("result with no query pending: value %0d", value);
        n_errors++;
        return;
      end
      want = expected_q.pop_front();
      if (value !== want.value) flag("value", want.value, value);
      if (front !== want.front) flag("in_front", want.front, front);
      if (sat !== want.sat) flag("saturated", want.sat, sat);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         mode;
  logic signed [31:0] distance;
  logic [15:0]        track_bearing;
  logic [15:0]        aircraft_bearing;
  logic signed [31:0] waypoint_altitude;
  logic signed [31:0] query_altitude;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] value;
  logic               in_front;
  logic               saturated;

  altitude_checker sb = new();
  bit tx_idle_on, rx_idle_on, hold_request;
  int n_cfg_writes, n_settings, quiet_cycles;

  landing_glide_flare_altitude #(.EXP_ITERATIONS(EXP_ITERATIONS)) u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .mode(mode), .distance(distance),
    .track_bearing(track_bearing), .aircraft_bearing(aircraft_bearing),
    .waypoint_altitude(waypoint_altitude), .query_altitude(query_altitude),
    .out_valid(out_valid), .out_ready(out_ready),
    .value(value), .in_front(in_front), .saturated(saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(cfg_reg_t'(cfg_index), cfg_data);
        n_cfg_writes++;
      end
      if (in_valid && in_ready)
        sb.note_query(mode, distance, track_bearing, aircraft_bearing,
                      waypoint_altitude, query_altitude);
      if (out_valid && out_ready)
        sb.check_answer(value, in_front, saturated);
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    @(posedge clk);
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("tb_landing_glide_flare_altitude NOT OK");
    $finish;
  end

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready = rx_idle_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
    end
  end

  task automatic cfg_write(cfg_reg_t idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic apply_config(logic [31:0] tan_v, logic [31:0] cot_v, logic [31:0] off_v,
                              logic [31:0] top_v, logic [31:0] virt_v, logic [31:0] len_v,
                              logic [31:0] rate_v);
    cfg_write(CFG_SLOPE_TANGENT, tan_v);
    cfg_write(CFG_SLOPE_COTANGENT, cot_v);
    cfg_write(CFG_SLOPE_OFFSET, off_v);
    cfg_write(CFG_FLARE_TOP_HEIGHT, top_v);
    cfg_write(CFG_VIRTUAL_HEIGHT, virt_v);
    cfg_write(CFG_FLARE_LENGTH, len_v);
    cfg_write(CFG_FLARE_RATE, rate_v);
    n_settings++;
  endtask

  task automatic send_query(logic [2:0] m, logic signed [31:0] d, logic [15:0] trk,
                            logic [15:0] crf, logic signed [31:0] wp, logic signed [31:0] qa);
    @(negedge clk);
    while (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid          = 1'b1;
    mode              = m;
    distance          = d;
    track_bearing     = trk;
    aircraft_bearing  = crf;
    waypoint_altitude = wp;
    query_altitude    = qa;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // distances cluster around the flare start and the slope offset
  task automatic send_random(int count);
    logic [2:0]         m;
    logic signed [31:0] d, wp, qa;
    logic [15:0]        trk, delta;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 90)
        m = 3'($urandom_range(MODE_DISTANCE));
      else
        m = 3'($urandom_range(MODE_TOP, MODE_DISTANCE + 1));
      case ($urandom_range(3))
        0: d = $urandom;
        1: d = sb.flare_len - $urandom_range(0, 20000000);
        2: d = sb.offset + $urandom_range(0, 40000000) - 20000000;
        default: d = $urandom_range(0, 40000000) - 5000000;
      endcase
      trk = $urandom;
      case ($urandom_range(2))
        0: delta = $urandom;
        1: delta = ($urandom_range(1) ? QUARTER_TURN : -QUARTER_TURN) + $urandom_range(0, 6) - 3;
        default: delta = $urandom_range(0, 4000) - 2000;
      endcase
      wp = $urandom_range(1) ? $urandom : $urandom_range(0, 6553600) - 3276800;
      qa = $urandom_range(1) ? $urandom : $urandom_range(0, 6553600) - 3276800;
      send_query(m, d, trk, trk + delta, wp, qa);
    end
  endtask

  task automatic end_phase();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = CFG_SLOPE_TANGENT;
    cfg_data = '0;
    in_valid = 1'b0;
    mode = MODE_SLOPE_REL;
    distance = '0;
    track_bearing = '0;
    aircraft_bearing = '0;
    waypoint_altitude = '0;
    query_altitude = '0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    hold_request = 1'b0;
    n_settings = 1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // registers still at their reset values
    send_random(40);
    end_phase();

    // a plausible approach: 5 degree slope, 30 m flare
    apply_config(32'd5734, 32'd749076, 32'd1572864, 32'd786432, 32'd131072,
                 32'd1966080, 32'd2516582);
    send_query(MODE_SLOPE_REL, 0, 0, 0, 0, 0);
    send_query(MODE_SLOPE_REL, 32'h7FFFFFFF, 16'hFFFF, 16'hFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_query(MODE_SLOPE_REL, 32'h80000000, 0, 0, 32'h80000000, 32'h80000000);
    send_query(MODE_SLOPE_GUARD, 6553600, 0, 16'd16383, 0, 0);
    send_query(MODE_SLOPE_GUARD, 6553600, 0, 16'd16384, 0, 0);
    send_query(MODE_SLOPE_GUARD, 6553600, 16'hFFFF, 16'h3FFE, 0, 0);
    send_query(MODE_FLARE, 655360, 16'd1000, 16'd50153, 0, 0);
    send_query(MODE_FLARE, 655360, 16'd1000, 16'd50152, 0, 0);
    send_query(MODE_FLARE, 655360, 0, 16'h8000, 0, 0);
    send_query(MODE_FLARE, 1966080, 16'd5, 16'd5, 0, 0);
    send_query(MODE_FLARE, 1966079, 0, 0, 0, 0);
    send_query(MODE_FLARE, 0, 0, 0, 0, 0);
    send_query(MODE_FLARE, 32'h7FFFFFFF, 0, 0, 0, 0);
    send_query(MODE_FLARE, 32'h80000000, 0, 0, 0, 0);
    // exponent just past and just short of the full shift range
    send_query(MODE_FLARE, -32'sd10158080, 0, 0, 0, 0);
    send_query(MODE_FLARE, -32'sd10092544, 0, 0, 0, 0);
    send_query(MODE_SLOPE_ABS, 32'h7FFFFFFF, 0, 0, 32'h7FFFFFFF, 0);
    send_query(MODE_SLOPE_ABS, 32'h80000000, 0, 0, 32'h80000000, 0);
    send_query(MODE_SLOPE_ABS, 6553600, 0, 0, 3276800, 0);
    send_query(MODE_DISTANCE, 0, 0, 0, 32'h80000000, 32'h7FFFFFFF);
    send_query(MODE_DISTANCE, 0, 0, 0, 32'h7FFFFFFF, 32'h80000000);
    send_query(MODE_DISTANCE, 0, 0, 0, 0, 655360);
    for (int m = MODE_DISTANCE + 1; m <= MODE_TOP; m++)
      send_query(3'(m), $urandom, $urandom, $urandom, $urandom, $urandom);

    // steady stream first, then random idling and one long output stall
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_random(150);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_random(60);
    hold_request = 1'b1;
    send_random(190);
    end_phase();

    apply_config(32'd262144, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                 32'h7FFFFFFF, 32'hFFFFFFFF);
    send_random(200);
    end_phase();

    apply_config(32'd262144, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                 32'h80000000, 32'd1);
    send_random(200);
    end_phase();

    for (int p = 0; p < 4; p++) begin
      logic [31:0] tan_v;
      tan_v = (p < 2) ? $urandom_range(1000, 20000) : $urandom_range(0, 262144);
      if (p < 2)
        apply_config(tan_v, 32'((64'd1 << 32) / tan_v),
                     $urandom_range(0, 6553600) - 3276800, $urandom_range(0, 3276800),
                     $urandom_range(0, 655360), $urandom_range(0, 6553600),
                     $urandom_range(100000, 20000000));
      else
        apply_config(tan_v, $urandom_range(0, 32'h7FFFFFFF), $urandom, $urandom,
                     $urandom, $urandom, $urandom);
      send_random(115);
      end_phase();
    end

    $display("covered %0d queries in all modes over %0d register settings (%0d writes)",
             sb.n_queries, n_settings, n_cfg_writes);
    $display("checked %0d results, %0d mismatches", sb.n_answers, sb.n_errors);
    if (sb.n_errors == 0 && sb.pending() == 0)
      $display("tb_landing_glide_flare_altitude OK");
    else
      $display("tb_landing_glide_flare_altitude NOT OK");
    $finish;
  end

endmodule
